FILE: src/ceht_pkg.sv
package ceht_pkg;

    localparam int NUM_ASICS      = 6;
    localparam int CORES_PER_ASIC = 256;
    localparam int QUEUE_DEPTH    = 2048;
    localparam int NUM_CORES      = NUM_ASICS * CORES_PER_ASIC;

    localparam int TBL_AW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int Q_AW   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int ASIC_W   = 3;
    localparam int CORE_W   = 8;
    localparam int JOB_W    = 15;
    localparam int TIME_W   = 48;
    localparam int PERIOD_W = 40;
    localparam int CNT_W    = 8;
    localparam int LJ_W     = 16;
    localparam int SUB_W    = TIME_W;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;

    localparam logic [1:0] REG_ERROR_LIMIT   = 2'd0;
    localparam logic [1:0] REG_DISABLE_LIMIT = 2'd1;
    localparam logic [1:0] REG_DISABLE_PERIOD = 2'd2;

    localparam logic [CNT_W-1:0]    ERROR_LIMIT_RST    = 8'd10;
    localparam logic [CNT_W-1:0]    DISABLE_LIMIT_RST  = 8'd3;
    localparam logic [PERIOD_W-1:0] DISABLE_PERIOD_RST = 40'd900000000;

    localparam logic [LJ_W-1:0]   JOB_NONE = 16'hFFFF;
    localparam logic [CNT_W-1:0]  CNT_MAX  = 8'hFF;
    localparam logic [QCNT_W-1:0] Q_FULL   = QCNT_W'(QUEUE_DEPTH);
    localparam logic [Q_AW-1:0]   Q_LAST   = Q_AW'(QUEUE_DEPTH - 1);
    localparam logic [TBL_AW-1:0] CLR_LAST = TBL_AW'(NUM_CORES - 1);

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_GOOD,
        ACT_ERROR,
        ACT_REPEAT,
        ACT_TEMP_OFF,
        ACT_PERM_OFF,
        ACT_REENABLED,
        ACT_RANGE
    } action_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NCHK,
        ST_NLIM,
        ST_NDIS,
        ST_TSUB,
        ST_TCMP,
        ST_TDEC,
        ST_TEXP,
        ST_TWR,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [CNT_W-1:0] error_count;
        logic [CNT_W-1:0] disable_count;
        logic [LJ_W-1:0]  last_job;
    } core_rec_t;

    localparam int REC_W = $bits(core_rec_t);

    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic [ASIC_W-1:0] asic;
        logic [CORE_W-1:0] core;
    } qentry_t;

    localparam int QE_W = $bits(qentry_t);

    typedef struct packed {
        logic [CNT_W-1:0]    error_limit;
        logic [CNT_W-1:0]    disable_limit;
        logic [PERIOD_W-1:0] period;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [SUB_W-1:0] a;
        logic [SUB_W-1:0] b;
    } sub_req_t;

    typedef struct packed {
        logic             borrow;
        logic [SUB_W-1:0] diff;
    } sub_rsp_t;

    function automatic logic in_range(input logic [ASIC_W-1:0] asic,
                                      input logic [CORE_W-1:0] core);
        return (int'(asic) < NUM_ASICS) && (int'(core) < CORES_PER_ASIC);
    endfunction

    function automatic logic [TBL_AW-1:0] core_addr(input logic [ASIC_W-1:0] asic,
                                                    input logic [CORE_W-1:0] core);
        int idx;
        idx = int'(asic) * CORES_PER_ASIC + int'(core);
        return idx[TBL_AW-1:0];
    endfunction

endpackage

FILE: src/core_error_health_tracker.sv
// Per-core health tracker: each in-range nonce report word other than a repeated one
// updates the error count, disable count and last bad work id of one core in a core table
// with one write and one read port, and a tick word re-enables the oldest core in the
// disable queue once its period has run out or the clock has gone backwards. Every word
// gives exactly one result word. After reset the core table is swept to its reset value,
// one core per cycle over all NUM_CORES (1536) cores, with s_ready low; the config port
// works during that pass. One word is handled at a time, stepping through states around
// the registered read of the core and queue tables and the single 48-bit subtractor that
// does every compare in turn (time difference, period, error limit, disable limit). A
// result word held by m_ready low holds the next word in ST_FIN, with s_ready low.
module core_error_health_tracker (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_kind,
    input  logic [ceht_pkg::ASIC_W-1:0]     s_asic_index,
    input  logic [ceht_pkg::CORE_W-1:0]     s_core_index,
    input  logic [ceht_pkg::JOB_W-1:0]      s_job_id,
    input  logic                            s_nonce_good,
    input  logic [ceht_pkg::TIME_W-1:0]     s_now_us,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [2:0]                      m_action,
    output logic [ceht_pkg::ASIC_W-1:0]     m_out_asic,
    output logic [ceht_pkg::CORE_W-1:0]     m_out_core,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ceht_pkg::PADDR_W-1:0]    paddr,
    input  logic [ceht_pkg::PDATA_W-1:0]    pwdata,
    output logic [ceht_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    ceht_pkg::state_t  state_reg, state_next;
    ceht_pkg::cfg_t    cfg;
    ceht_pkg::sub_req_t sub_req;
    ceht_pkg::sub_rsp_t sub_rsp;

    logic [ceht_pkg::TBL_AW-1:0] clr_reg, clr_next;
    logic [ceht_pkg::Q_AW-1:0]   head_reg, head_next;
    logic [ceht_pkg::QCNT_W-1:0] qcount_reg, qcount_next;

    logic [ceht_pkg::ASIC_W-1:0]   asic_reg, asic_next;
    logic [ceht_pkg::CORE_W-1:0]   core_reg, core_next;
    logic [ceht_pkg::JOB_W-1:0]    job_reg, job_next;
    logic                          good_reg, good_next;
    logic [ceht_pkg::TIME_W-1:0]   now_reg, now_next;

    logic [ceht_pkg::TBL_AW-1:0]   tbl_addr_reg, tbl_addr_next;
    logic [ceht_pkg::CNT_W-1:0]    ec_reg, ec_next;
    logic [ceht_pkg::CNT_W-1:0]    dc_reg, dc_next;
    logic [ceht_pkg::ASIC_W-1:0]   ent_asic_reg, ent_asic_next;
    logic [ceht_pkg::CORE_W-1:0]   ent_core_reg, ent_core_next;

    ceht_pkg::action_t             res_action_reg, res_action_next;
    logic [ceht_pkg::ASIC_W-1:0]   res_asic_reg, res_asic_next;
    logic [ceht_pkg::CORE_W-1:0]   res_core_reg, res_core_next;

    logic                          m_valid_reg, m_valid_next;
    ceht_pkg::action_t             m_action_reg, m_action_next;
    logic [ceht_pkg::ASIC_W-1:0]   m_asic_reg, m_asic_next;
    logic [ceht_pkg::CORE_W-1:0]   m_core_reg, m_core_next;

    logic                          tbl_we, tbl_re;
    logic [ceht_pkg::TBL_AW-1:0]   tbl_waddr, tbl_raddr;
    ceht_pkg::core_rec_t           tbl_wdata, tbl_rec;
    logic [ceht_pkg::REC_W-1:0]    tbl_rdata;

    logic                          q_we, q_re;
    ceht_pkg::qentry_t             q_wdata, q_rec;
    logic [ceht_pkg::QE_W-1:0]     q_rdata;
    logic [ceht_pkg::Q_AW-1:0]     tail;
    logic [ceht_pkg::QCNT_W:0]     tail_sum;

    logic [ceht_pkg::CNT_W-1:0]    ec_sat, dc_sat;

    ceht_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ceht_sub u_sub (
        .aclk (aclk),
        .req  (sub_req),
        .rsp  (sub_rsp)
    );

    ceht_ram #(
        .WIDTH (ceht_pkg::REC_W),
        .DEPTH (ceht_pkg::NUM_CORES)
    ) u_core_tbl (
        .aclk    (aclk),
        .wr_en   (tbl_we),
        .wr_addr (tbl_waddr),
        .wr_data (tbl_wdata),
        .rd_en   (tbl_re),
        .rd_addr (tbl_raddr),
        .rd_data (tbl_rdata)
    );

    ceht_ram #(
        .WIDTH (ceht_pkg::QE_W),
        .DEPTH (ceht_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .wr_en   (q_we),
        .wr_addr (tail),
        .wr_data (q_wdata),
        .rd_en   (q_re),
        .rd_addr (head_reg),
        .rd_data (q_rdata)
    );

    assign tbl_rec = ceht_pkg::core_rec_t'(tbl_rdata);
    assign q_rec   = ceht_pkg::qentry_t'(q_rdata);
    assign q_wdata = {now_reg, asic_reg, core_reg};

    // tail = head + count, wrapped once
    assign tail_sum = (ceht_pkg::QCNT_W + 1)'(head_reg) + (ceht_pkg::QCNT_W + 1)'(qcount_reg);
    assign tail = (tail_sum >= (ceht_pkg::QCNT_W + 1)'(ceht_pkg::QUEUE_DEPTH))
                ? ceht_pkg::Q_AW'(tail_sum - (ceht_pkg::QCNT_W + 1)'(ceht_pkg::QUEUE_DEPTH))
                : tail_sum[ceht_pkg::Q_AW-1:0];

    assign ec_sat = (tbl_rec.error_count == ceht_pkg::CNT_MAX)
                  ? tbl_rec.error_count : tbl_rec.error_count + 1'b1;
    assign dc_sat = (dc_reg == ceht_pkg::CNT_MAX) ? dc_reg : dc_reg + 1'b1;

    assign s_ready    = (state_reg == ceht_pkg::ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_action   = m_action_reg;
    assign m_out_asic = m_asic_reg;
    assign m_out_core = m_core_reg;

    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        head_next       = head_reg;
        qcount_next     = qcount_reg;
        asic_next       = asic_reg;
        core_next       = core_reg;
        job_next        = job_reg;
        good_next       = good_reg;
        now_next        = now_reg;
        tbl_addr_next   = tbl_addr_reg;
        ec_next         = ec_reg;
        dc_next         = dc_reg;
        ent_asic_next   = ent_asic_reg;
        ent_core_next   = ent_core_reg;
        res_action_next = res_action_reg;
        res_asic_next   = res_asic_reg;
        res_core_next   = res_core_reg;
        m_valid_next    = m_valid_reg;
        m_action_next   = m_action_reg;
        m_asic_next     = m_asic_reg;
        m_core_next     = m_core_reg;
        tbl_we          = 1'b0;
        tbl_waddr       = tbl_addr_reg;
        tbl_wdata       = {ceht_pkg::CNT_W'(0), ceht_pkg::CNT_W'(0), ceht_pkg::JOB_NONE};
        tbl_re          = 1'b0;
        tbl_raddr       = ceht_pkg::core_addr(s_asic_index, s_core_index);
        q_we            = 1'b0;
        q_re            = 1'b0;
        sub_req         = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ceht_pkg::ST_CLEAR: begin
                tbl_we    = 1'b1;
                tbl_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == ceht_pkg::CLR_LAST) begin
                    state_next = ceht_pkg::ST_IDLE;
                end
            end
            ceht_pkg::ST_IDLE: begin
                if (s_valid) begin
                    asic_next = s_asic_index;
                    core_next = s_core_index;
                    job_next  = s_job_id;
                    good_next = s_nonce_good;
                    now_next  = s_now_us;
                    if (s_kind) begin
                        if (qcount_reg == '0) begin
                            res_action_next = ceht_pkg::ACT_NONE;
                            res_asic_next   = '0;
                            res_core_next   = '0;
                            state_next      = ceht_pkg::ST_FIN;
                        end else begin
                            q_re       = 1'b1;
                            state_next = ceht_pkg::ST_TSUB;
                        end
                    end else if (!ceht_pkg::in_range(s_asic_index, s_core_index)) begin
                        res_action_next = ceht_pkg::ACT_RANGE;
                        res_asic_next   = s_asic_index;
                        res_core_next   = s_core_index;
                        state_next      = ceht_pkg::ST_FIN;
                    end else begin
                        tbl_re        = 1'b1;
                        tbl_addr_next = ceht_pkg::core_addr(s_asic_index, s_core_index);
                        state_next    = ceht_pkg::ST_NCHK;
                    end
                end
            end
            ceht_pkg::ST_NCHK: begin
                res_asic_next = asic_reg;
                res_core_next = core_reg;
                if (good_reg) begin
                    tbl_we          = 1'b1;
                    res_action_next = ceht_pkg::ACT_GOOD;
                    state_next      = ceht_pkg::ST_FIN;
                end else if (tbl_rec.last_job == ceht_pkg::LJ_W'(job_reg)) begin
                    res_action_next = ceht_pkg::ACT_REPEAT;
                    state_next      = ceht_pkg::ST_FIN;
                end else begin
                    ec_next       = ec_sat;
                    dc_next       = tbl_rec.disable_count;
                    sub_req.start = 1'b1;
                    sub_req.a     = ceht_pkg::SUB_W'(ec_sat);
                    sub_req.b     = ceht_pkg::SUB_W'(cfg.error_limit);
                    state_next    = ceht_pkg::ST_NLIM;
                end
            end
            ceht_pkg::ST_NLIM: begin
                if (sub_rsp.borrow) begin
                    // still below the error limit
                    tbl_we          = 1'b1;
                    tbl_wdata       = {ec_reg, dc_reg, ceht_pkg::LJ_W'(job_reg)};
                    res_action_next = ceht_pkg::ACT_ERROR;
                    state_next      = ceht_pkg::ST_FIN;
                end else begin
                    dc_next       = dc_sat;
                    sub_req.start = 1'b1;
                    sub_req.a     = ceht_pkg::SUB_W'(dc_sat);
                    sub_req.b     = ceht_pkg::SUB_W'(cfg.disable_limit);
                    state_next    = ceht_pkg::ST_NDIS;
                end
            end
            ceht_pkg::ST_NDIS: begin
                tbl_we    = 1'b1;
                tbl_wdata = {ec_reg, dc_reg, ceht_pkg::LJ_W'(job_reg)};
                if (!sub_rsp.borrow) begin
                    res_action_next = ceht_pkg::ACT_PERM_OFF;
                end else begin
                    // a full queue drops the entry but still reports the disable
                    if (qcount_reg < ceht_pkg::Q_FULL) begin
                        q_we        = 1'b1;
                        qcount_next = qcount_reg + 1'b1;
                    end
                    res_action_next = ceht_pkg::ACT_TEMP_OFF;
                end
                state_next = ceht_pkg::ST_FIN;
            end
            ceht_pkg::ST_TSUB: begin
                ent_asic_next = q_rec.asic;
                ent_core_next = q_rec.core;
                sub_req.start = 1'b1;
                sub_req.a     = now_reg;
                sub_req.b     = q_rec.stamp;
                state_next    = ceht_pkg::ST_TCMP;
            end
            ceht_pkg::ST_TCMP: begin
                // time running backwards counts as expired
                if (sub_rsp.borrow) begin
                    state_next = ceht_pkg::ST_TEXP;
                end else begin
                    sub_req.start = 1'b1;
                    sub_req.a     = sub_rsp.diff;
                    sub_req.b     = ceht_pkg::SUB_W'(cfg.period);
                    state_next    = ceht_pkg::ST_TDEC;
                end
            end
            ceht_pkg::ST_TDEC: begin
                if (sub_rsp.borrow) begin
                    res_action_next = ceht_pkg::ACT_NONE;
                    res_asic_next   = '0;
                    res_core_next   = '0;
                    state_next      = ceht_pkg::ST_FIN;
                end else begin
                    state_next = ceht_pkg::ST_TEXP;
                end
            end
            ceht_pkg::ST_TEXP: begin
                head_next       = (head_reg == ceht_pkg::Q_LAST) ? '0 : head_reg + 1'b1;
                qcount_next     = qcount_reg - 1'b1;
                res_action_next = ceht_pkg::ACT_REENABLED;
                res_asic_next   = ent_asic_reg;
                res_core_next   = ent_core_reg;
                if (ceht_pkg::in_range(ent_asic_reg, ent_core_reg)) begin
                    tbl_re        = 1'b1;
                    tbl_raddr     = ceht_pkg::core_addr(ent_asic_reg, ent_core_reg);
                    tbl_addr_next = ceht_pkg::core_addr(ent_asic_reg, ent_core_reg);
                    state_next    = ceht_pkg::ST_TWR;
                end else begin
                    state_next = ceht_pkg::ST_FIN;
                end
            end
            ceht_pkg::ST_TWR: begin
                tbl_we     = 1'b1;
                tbl_wdata  = {ceht_pkg::CNT_W'(0), tbl_rec.disable_count, tbl_rec.last_job};
                state_next = ceht_pkg::ST_FIN;
            end
            ceht_pkg::ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_action_next = res_action_reg;
                    m_asic_next   = res_asic_reg;
                    m_core_next   = res_core_reg;
                    state_next    = ceht_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ceht_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ceht_pkg::ST_CLEAR;
            clr_reg     <= '0;
            head_reg    <= '0;
            qcount_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            head_reg    <= head_next;
            qcount_reg  <= qcount_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        asic_reg       <= asic_next;
        core_reg       <= core_next;
        job_reg        <= job_next;
        good_reg       <= good_next;
        now_reg        <= now_next;
        tbl_addr_reg   <= tbl_addr_next;
        ec_reg         <= ec_next;
        dc_reg         <= dc_next;
        ent_asic_reg   <= ent_asic_next;
        ent_core_reg   <= ent_core_next;
        res_action_reg <= res_action_next;
        res_asic_reg   <= res_asic_next;
        res_core_reg   <= res_core_next;
        m_action_reg   <= m_action_next;
        m_asic_reg     <= m_asic_next;
        m_core_reg     <= m_core_next;
    end

    a_qcount_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        qcount_reg <= ceht_pkg::Q_FULL)
        else $error("disable queue count above its depth");

    a_qcount_source: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && qcount_reg != $past(qcount_reg)) |->
            ($past(state_reg) == ceht_pkg::ST_NDIS || $past(state_reg) == ceht_pkg::ST_TEXP))
        else $error("queue count changed outside a disable or re-enable");

    a_word_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $rose(m_valid)) |-> ($past(state_reg) == ceht_pkg::ST_FIN))
        else $error("result word appeared without finishing an item");

    a_range_echo: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_action == ceht_pkg::ACT_RANGE) |->
            !ceht_pkg::in_range(m_out_asic, m_out_core))
        else $error("out of range result for a core that exists");

    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ceht_pkg::ST_CLEAR) |=>
            (state_reg == ceht_pkg::ST_CLEAR || state_reg == ceht_pkg::ST_IDLE))
        else $error("left the table clear pass into item work");

endmodule

FILE: src/ceht_ram.sv
module ceht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/ceht_sub.sv
module ceht_sub (
    input  logic                aclk,
    input  ceht_pkg::sub_req_t  req,
    output ceht_pkg::sub_rsp_t  rsp
);

    logic [ceht_pkg::SUB_W:0] full_diff;
    ceht_pkg::sub_rsp_t       rsp_reg;

    // top bit of the widened difference is the borrow, i.e. a < b
    assign full_diff = {1'b0, req.a} - {1'b0, req.b};

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rsp_reg.borrow <= full_diff[ceht_pkg::SUB_W];
            rsp_reg.diff   <= full_diff[ceht_pkg::SUB_W-1:0];
        end
    end

    assign rsp = rsp_reg;

endmodule

FILE: src/ceht_cfg.sv
module ceht_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ceht_pkg::PADDR_W-1:0]  paddr,
    input  logic [ceht_pkg::PDATA_W-1:0]  pwdata,
    output logic [ceht_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output ceht_pkg::cfg_t                cfg
);

    ceht_pkg::cfg_t cfg_reg;
    ceht_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [1:0]     reg_sel;

    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[ceht_pkg::PADDR_W-1:3];
    assign pready  = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_sel)
                ceht_pkg::REG_ERROR_LIMIT: begin
                    cfg_next.error_limit = pwdata[ceht_pkg::CNT_W-1:0];
                end
                ceht_pkg::REG_DISABLE_LIMIT: begin
                    cfg_next.disable_limit = pwdata[ceht_pkg::CNT_W-1:0];
                end
                ceht_pkg::REG_DISABLE_PERIOD: begin
                    cfg_next.period = pwdata[ceht_pkg::PERIOD_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            ceht_pkg::REG_ERROR_LIMIT: begin
                prdata = ceht_pkg::PDATA_W'(cfg_reg.error_limit);
            end
            ceht_pkg::REG_DISABLE_LIMIT: begin
                prdata = ceht_pkg::PDATA_W'(cfg_reg.disable_limit);
            end
            ceht_pkg::REG_DISABLE_PERIOD: begin
                prdata = ceht_pkg::PDATA_W'(cfg_reg.period);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.error_limit   <= ceht_pkg::ERROR_LIMIT_RST;
            cfg_reg.disable_limit <= ceht_pkg::DISABLE_LIMIT_RST;
            cfg_reg.period        <= ceht_pkg::DISABLE_PERIOD_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: verif/core_health_checker.sv
module core_health_checker
    import ceht_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    input  logic                s_ready,
    input  logic                s_kind,
    input  logic [ASIC_W-1:0]   s_asic_index,
    input  logic [CORE_W-1:0]   s_core_index,
    input  logic [JOB_W-1:0]    s_job_id,
    input  logic                s_nonce_good,
    input  logic [TIME_W-1:0]   s_now_us,

    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [2:0]          m_action,
    input  logic [ASIC_W-1:0]   m_out_asic,
    input  logic [CORE_W-1:0]   m_out_core,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    input  logic                pready,

    output int unsigned         mismatches,
    output int unsigned         outstanding
);

    typedef struct {
        action_t           act;
        logic [ASIC_W-1:0] asic;
        logic [CORE_W-1:0] core;
    } health_word_t;

    logic [CNT_W-1:0]    bad_count    [NUM_CORES];
    logic [CNT_W-1:0]    off_count    [NUM_CORES];
    logic [LJ_W-1:0]     last_bad_job [NUM_CORES];
    qentry_t             off_queue    [QUEUE_DEPTH];
    int unsigned         off_head;
    int unsigned         off_used;

    logic [CNT_W-1:0]    lim_err;
    logic [CNT_W-1:0]    lim_off;
    logic [PERIOD_W-1:0] off_period;

    health_word_t        expected_actions [$];
    int unsigned         fail_cnt = 0;

    assign mismatches = fail_cnt;

    task automatic predict_health_action();
        health_word_t w;
        qentry_t      ent;
        int           idx;
        int unsigned  tail;
        logic         expired;
        w.act  = ACT_NONE;
        w.asic = '0;
        w.core = '0;
        if (s_kind) begin
            if (off_used != 0) begin
                ent = off_queue[off_head];
                // a stamp in the future counts as already expired
                if (s_now_us < ent.stamp) expired = 1'b1;
                else expired = (s_now_us - ent.stamp) >= TIME_W'(off_period);
                if (expired) begin
                    idx = int'(ent.asic) * CORES_PER_ASIC + int'(ent.core);
                    if (idx < NUM_CORES) bad_count[idx] = '0;
                    w.act  = ACT_REENABLED;
                    w.asic = ent.asic;
                    w.core = ent.core;
                    off_head = (off_head == QUEUE_DEPTH - 1) ? 0 : off_head + 1;
                    off_used--;
                end
            end
        end else if (int'(s_asic_index) >= NUM_ASICS || int'(s_core_index) >= CORES_PER_ASIC) begin
            w.act  = ACT_RANGE;
            w.asic = s_asic_index;
            w.core = s_core_index;
        end else begin
            idx    = int'(s_asic_index) * CORES_PER_ASIC + int'(s_core_index);
            w.asic = s_asic_index;
            w.core = s_core_index;
            if (s_nonce_good) begin
                bad_count[idx]    = '0;
                off_count[idx]    = '0;
                last_bad_job[idx] = JOB_NONE;
                w.act = ACT_GOOD;
            end else if (last_bad_job[idx] == LJ_W'(s_job_id)) begin
                w.act = ACT_REPEAT;
            end else begin
                last_bad_job[idx] = LJ_W'(s_job_id);
                if (bad_count[idx] != CNT_MAX) bad_count[idx]++;
                if (bad_count[idx] < lim_err) begin
                    w.act = ACT_ERROR;
                end else begin
                    if (off_count[idx] != CNT_MAX) off_count[idx]++;
                    if (off_count[idx] >= lim_off) begin
                        w.act = ACT_PERM_OFF;
                    end else begin
                        // full queue still reports the disable but drops the entry
                        if (off_used < QUEUE_DEPTH) begin
                            tail = off_head + off_used;
                            if (tail >= QUEUE_DEPTH) tail -= QUEUE_DEPTH;
                            off_queue[tail].stamp = s_now_us;
                            off_queue[tail].asic  = s_asic_index;
                            off_queue[tail].core  = s_core_index;
                            off_used++;
                        end
                        w.act = ACT_TEMP_OFF;
                    end
                end
            end
        end
        expected_actions.push_back(w);
    endtask

    task automatic check_result();
        health_word_t want;
        if (expected_actions.size() == 0) begin
            fail_cnt++;
            if (fail_cnt <= 10)
                $display("unexpected result word: action %0d asic %0d core %0d",
                         m_action, m_out_asic, m_out_core);
            return;
        end
        want = expected_actions.pop_front();
        if (m_action !== want.act || m_out_asic !== want.asic || m_out_core !== want.core) begin
            fail_cnt++;
            if (fail_cnt <= 10)
                $display("mismatch: expected action %0d asic %0d core %0d, got action %0d asic %0d core %0d",
                         want.act, want.asic, want.core, m_action, m_out_asic, m_out_core);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CORES; i++) begin
                bad_count[i]    = '0;
                off_count[i]    = '0;
                last_bad_job[i] = JOB_NONE;
            end
            off_head   = 0;
            off_used   = 0;
            lim_err    = ERROR_LIMIT_RST;
            lim_off    = DISABLE_LIMIT_RST;
            off_period = DISABLE_PERIOD_RST;
            expected_actions.delete();
        end else begin
            // result first: a word leaving now belongs to an earlier input
            if (m_valid && m_ready) check_result();
            if (s_valid && s_ready) predict_health_action();
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:3])
                    REG_ERROR_LIMIT:    lim_err    = pwdata[CNT_W-1:0];
                    REG_DISABLE_LIMIT:  lim_off    = pwdata[CNT_W-1:0];
                    REG_DISABLE_PERIOD: off_period = pwdata[PERIOD_W-1:0];
                    default: ;
                endcase
            end
        end
        outstanding <= expected_actions.size();
    end

endmodule

FILE: verif/core_error_health_tracker_tb.sv
module core_error_health_tracker_tb;
    import ceht_pkg::*;

    localparam int unsigned LIMIT       = 2000000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_kind = 1'b0;
    logic [ASIC_W-1:0]   s_asic_index = '0;
    logic [CORE_W-1:0]   s_core_index = '0;
    logic [JOB_W-1:0]    s_job_id = '0;
    logic                s_nonce_good = 1'b0;
    logic [TIME_W-1:0]   s_now_us = '0;

    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [2:0]          m_action;
    logic [ASIC_W-1:0]   m_out_asic;
    logic [CORE_W-1:0]   m_out_core;

    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned cycle_cnt = 0;

    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    bit hold_off_req = 1'b0;
    logic [TIME_W-1:0] clock_us;

    always #5 aclk = ~aclk;

    core_error_health_tracker dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_asic_index (s_asic_index),
        .s_core_index (s_core_index),
        .s_job_id     (s_job_id),
        .s_nonce_good (s_nonce_good),
        .s_now_us     (s_now_us),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_action     (m_action),
        .m_out_asic   (m_out_asic),
        .m_out_core   (m_out_core),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    core_health_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_asic_index (s_asic_index),
        .s_core_index (s_core_index),
        .s_job_id     (s_job_id),
        .s_nonce_good (s_nonce_good),
        .s_now_us     (s_now_us),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_action     (m_action),
        .m_out_asic   (m_out_asic),
        .m_out_core   (m_out_core),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 80);
    endfunction

    initial begin : rx_side
        int unsigned n;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_off_req = 1'b0;
            end else if (rx_quiet) begin
                m_ready <= 1'b1;
            end else begin
                n = pick_gap();
                if (n == 0) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b0;
                    repeat (n - 1) @(negedge aclk);
                end
            end
        end
    end

    task automatic send_word(input logic k, input logic [ASIC_W-1:0] a,
                             input logic [CORE_W-1:0] c, input logic [JOB_W-1:0] j,
                             input logic g, input logic [TIME_W-1:0] t);
        int unsigned gap;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap != 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_kind       <= k;
        s_asic_index <= a;
        s_core_index <= c;
        s_job_id     <= j;
        s_nonce_good <= g;
        s_now_us     <= t;
        s_valid      <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [PDATA_W-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_limits(input logic [CNT_W-1:0] err_lim, input logic [CNT_W-1:0] off_lim,
                               input logic [PERIOD_W-1:0] per);
        wait_idle();
        apb_write(REG_ERROR_LIMIT, PDATA_W'(err_lim));
        apb_write(REG_DISABLE_LIMIT, PDATA_W'(off_lim));
        apb_write(REG_DISABLE_PERIOD, PDATA_W'(per));
    endtask

    // hot cores get most reports so counts climb far enough to disable
    task automatic send_random(input int unsigned n_items, input bit with_hold);
        int unsigned i, r;
        logic k, g;
        logic [ASIC_W-1:0] a;
        logic [CORE_W-1:0] c;
        logic [JOB_W-1:0] j;
        for (i = 0; i < n_items; i++) begin
            if (i % 100 == 0) begin
                tx_quiet = ($urandom_range(0, 3) == 0);
                rx_quiet = ($urandom_range(0, 3) == 0);
            end
            if (with_hold && i == n_items / 2) hold_off_req = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 5) clock_us = {16'($urandom), 32'($urandom)};
            else if (r < 10) clock_us = clock_us - $urandom_range(1, 500);
            else clock_us = clock_us + $urandom_range(0, 300);
            k = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 85) begin
                a = 3'($urandom_range(0, NUM_ASICS - 1));
                c = $urandom_range(0, 1) ? 8'($urandom_range(0, 1)) : 8'(254 + $urandom_range(0, 1));
                j = ($urandom_range(0, 99) < 85) ? 15'($urandom_range(0, 3)) : 15'($urandom);
                g = ($urandom_range(0, 9) == 0);
            end else begin
                a = 3'($urandom);
                c = 8'($urandom);
                j = 15'($urandom);
                g = 1'($urandom);
            end
            send_word(k, a, c, j, g, clock_us);
        end
    endtask

    initial begin : stimulus
        int unsigned i;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset limits: empty tick, out of range, good, counted and repeated errors
        send_word(1'b1, 3'd0, 8'd0, 15'd0, 1'b0, 48'd0);
        send_word(1'b0, 3'd7, 8'd255, 15'h7FFF, 1'b0, 48'd10);
        send_word(1'b0, 3'd6, 8'd0, 15'd0, 1'b1, 48'd20);
        send_word(1'b0, 3'd0, 8'd0, 15'h7FFF, 1'b1, '1);
        send_word(1'b0, 3'd5, 8'd255, 15'h7FFF, 1'b0, 48'd30);
        send_word(1'b0, 3'd5, 8'd255, 15'h7FFF, 1'b0, 48'd31);
        send_word(1'b0, 3'd5, 8'd255, 15'd0, 1'b0, 48'd32);
        send_word(1'b0, 3'd5, 8'd255, 15'd0, 1'b1, 48'd33);

        // zero limits: first counted error disables for good
        load_limits(8'd0, 8'd0, 40'd100);
        send_word(1'b0, 3'd1, 8'd1, 15'd5, 1'b0, 48'd40);

        // temp disable, unexpired tick, expiry on the exact period, clock going backwards
        load_limits(8'd1, 8'd2, 40'd100);
        send_word(1'b0, 3'd2, 8'd3, 15'd1, 1'b0, 48'd1000);
        send_word(1'b1, 3'd0, 8'd0, 15'd0, 1'b0, 48'd1050);
        send_word(1'b1, 3'd0, 8'd0, 15'd0, 1'b0, 48'd1100);
        send_word(1'b0, 3'd2, 8'd3, 15'd2, 1'b0, 48'd2000);
        send_word(1'b0, 3'd3, 8'd128, 15'd9, 1'b0, 48'd5000);
        send_word(1'b1, 3'd7, 8'd255, 15'h7FFF, 1'b1, 48'd5);
        send_word(1'b1, 3'd0, 8'd0, 15'd0, 1'b0, 48'd6000);

        load_limits(8'd255, 8'd255, PERIOD_MAX);
        send_word(1'b0, 3'd4, 8'd200, 15'd3, 1'b0, 48'd0);
        send_word(1'b1, 3'd0, 8'd0, 15'd0, 1'b0, 48'd0);

        clock_us = 48'($urandom);
        load_limits(8'd4, 8'd3, 40'd200);
        send_random(300, 1'b1);
        load_limits(8'd1, 8'd255, 40'd0);
        send_random(200, 1'b0);
        load_limits(8'd2, 8'd200, PERIOD_MAX);
        send_random(200, 1'b1);
        load_limits(8'd255, 8'd1, 40'd1000);
        send_random(150, 1'b0);
        load_limits(8'd0, 8'd5, 40'd50);
        send_random(200, 1'b1);

        // flood nine cores with fresh bad work ids: a long run of temp disables deepens the queue
        load_limits(8'd1, 8'd255, PERIOD_MAX);
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        for (i = 0; i < 700; i++) begin
            clock_us = clock_us + 1;
            send_word(1'b0, 3'((i % 9) % NUM_ASICS), 8'(100 + i % 9), 15'($urandom), 1'b0,
                      clock_us);
        end

        load_limits(8'd1, 8'd255, 40'd0);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        for (i = 0; i < 40; i++) begin
            clock_us = clock_us + $urandom_range(0, 50);
            send_word(1'b1, 3'($urandom), 8'($urandom), 15'($urandom), 1'($urandom), clock_us);
        end

        wait_idle();
        repeat (20) @(negedge aclk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: core_error_health_tracker.f
src/ceht_pkg.sv
src/ceht_ram.sv
src/ceht_sub.sv
src/ceht_cfg.sv
src/core_error_health_tracker.sv
verif/core_health_checker.sv
verif/core_error_health_tracker_tb.sv
